// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rc4ks_pkg.sv
`timescale 1ns / 1ps

package rc4ks_pkg;

  localparam int TBL_DEPTH = 256;
  localparam int ADDR_W    = $clog2(TBL_DEPTH);
  localparam int DATA_W    = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DATA_W-1:0] byte_t;

  localparam addr_t ADDR_LAST = addr_t'(TBL_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_SINIT = 4'd1,
    ST_K0    = 4'd2,
    ST_K1    = 4'd3,
    ST_K2    = 4'd4,
    ST_K3    = 4'd5,
    ST_POST  = 4'd6,
    ST_G0    = 4'd7,
    ST_G1    = 4'd8,
    ST_G2    = 4'd9,
    ST_G3    = 4'd10,
    ST_EMIT  = 4'd11
  } step_t;

  typedef enum logic [2:0] {
    C_SEQ,
    C_GOTO,
    C_DISPATCH,
    C_LOOP_K,
    C_WAIT_OUT
  } cond_t;

  typedef enum logic [1:0] {
    RA_I,
    RA_I_INC,
    RA_J_SUM,
    RA_TA_SUM
  } ra_sel_t;

  typedef enum logic [1:0] {
    I_HOLD,
    I_ZERO,
    I_INC
  } i_op_t;

  typedef enum logic [1:0] {
    J_HOLD,
    J_ZERO,
    J_SUM
  } j_op_t;

  typedef enum logic {
    WA_I,
    WA_J
  } wa_sel_t;

  typedef enum logic {
    WD_RD,
    WD_TA
  } wd_sel_t;

  typedef struct packed {
    ra_sel_t ra_sel;
    i_op_t   i_op;
    j_op_t   j_op;
    logic    add_key;
    logic    we;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    ld_ta;
    logic    ld_tb;
    logic    ld_sel;
    logic    ld_res;
    logic    emit;
    logic    vld_clr;
  } dp_ctl_t;

  typedef struct packed {
    cond_t   cond;
    step_t   target;
    logic    take_in;
    dp_ctl_t dp;
  } ucw_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } dp_stat_t;

  // Control store: one word per step.
  function automatic ucw_t ctl_rom(step_t st);
    ucw_t w;
    w        = '0;
    w.cond   = C_GOTO;
    w.target = ST_IDLE;
    case (st)
      ST_IDLE: begin
        w.cond    = C_DISPATCH;
        w.target  = ST_G0;
        w.take_in = 1'b1;
      end
      ST_SINIT: begin
        w.cond       = C_SEQ;
        w.dp.vld_clr = 1'b1;
        w.dp.i_op    = I_ZERO;
        w.dp.j_op    = J_ZERO;
      end
      ST_K0: begin
        w.cond      = C_SEQ;
        w.dp.ra_sel = RA_I;
      end
      ST_K1: begin
        w.cond       = C_SEQ;
        w.dp.ld_ta   = 1'b1;
        w.dp.add_key = 1'b1;
        w.dp.j_op    = J_SUM;
        w.dp.ra_sel  = RA_J_SUM;
      end
      ST_K2: begin
        w.cond      = C_SEQ;
        w.dp.we     = 1'b1;
        w.dp.wa_sel = WA_I;
        w.dp.wd_sel = WD_RD;
      end
      ST_K3: begin
        w.cond      = C_LOOP_K;
        w.target    = ST_K0;
        w.dp.we     = 1'b1;
        w.dp.wa_sel = WA_J;
        w.dp.wd_sel = WD_TA;
        w.dp.i_op   = I_INC;
      end
      ST_POST: begin
        w.cond    = C_SEQ;
        w.dp.j_op = J_ZERO;
      end
      ST_G0: begin
        w.cond      = C_SEQ;
        w.dp.ra_sel = RA_I_INC;
        w.dp.i_op   = I_INC;
      end
      ST_G1: begin
        w.cond      = C_SEQ;
        w.dp.ld_ta  = 1'b1;
        w.dp.j_op   = J_SUM;
        w.dp.ra_sel = RA_J_SUM;
      end
      ST_G2: begin
        w.cond      = C_SEQ;
        w.dp.ld_tb  = 1'b1;
        w.dp.ld_sel = 1'b1;
        w.dp.ra_sel = RA_TA_SUM;
        w.dp.we     = 1'b1;
        w.dp.wa_sel = WA_I;
        w.dp.wd_sel = WD_RD;
      end
      ST_G3: begin
        w.cond      = C_SEQ;
        w.dp.ld_res = 1'b1;
        w.dp.we     = 1'b1;
        w.dp.wa_sel = WA_J;
        w.dp.wd_sel = WD_TA;
      end
      ST_EMIT: begin
        w.cond    = C_WAIT_OUT;
        w.target  = ST_IDLE;
        w.dp.emit = 1'b1;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/rc4_keystream_generator.sv
`timescale 1ns / 1ps
// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------
// input     | in_valid / in_stall | restart
// output    | out_valid/out_stall | keystream_byte [7:0]
// key write | key_byte_we         | key_byte [7:0]
//
// A beat without restart runs from acceptance to the next acceptance through
// dispatch, four steps on the permutation RAM, and the hand-off to output.
// A restart beat adds an init step, 256 rounds of steps K0 to K3 and a post step.
// Reset gives the identity permutation at once through per-entry valid bits.
// A stalled output holds the sequencer in its hand-off step; input is taken only
// in the dispatch step.

module rc4_keystream_generator (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    key_byte_we,
  input  rc4ks_pkg::byte_t        key_byte,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output rc4ks_pkg::byte_t        keystream_byte
);

  import rc4ks_pkg::*;

  byte_t    key_reg;
  dp_ctl_t  ctl;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg <= '0;
    end else if (key_byte_we) begin
      key_reg <= key_byte;
    end
  end

  rc4ks_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .stat     (stat),
    .ctl      (ctl)
  );

  rc4ks_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .key            (key_reg),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keystream_byte (keystream_byte)
  );

endmodule

// File: hw/rtl/rc4ks_ram.sv
`timescale 1ns / 1ps

module rc4ks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rc4ks_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4ks_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                restart,
  input  rc4ks_pkg::dp_stat_t stat,
  output rc4ks_pkg::dp_ctl_t  ctl
);

  import rc4ks_pkg::*;

  step_t pc;
  step_t pc_next;
  ucw_t  w;
  step_t pc_inc;

  assign w        = ctl_rom(pc);
  assign pc_inc   = step_t'(pc + 4'd1);
  assign ctl      = w.dp;
  assign in_stall = !w.take_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    pc_next = pc;
    case (w.cond)
      C_SEQ:  pc_next = pc_inc;
      C_GOTO: pc_next = w.target;
      C_DISPATCH: begin
        if (in_valid) begin
          pc_next = restart ? pc_inc : w.target;
        end
      end
      C_LOOP_K:   pc_next = stat.i_last ? pc_inc : w.target;
      C_WAIT_OUT: pc_next = stat.out_free ? w.target : pc;
      default:    pc_next = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_go_gen, (in_valid && !in_stall && !restart) |=> (pc == ST_G0), "no generation")
  `ASSERT_CLK(a_go_sched, (in_valid && !in_stall && restart) |=> (pc == ST_SINIT), "no schedule")
  `ASSERT_CLK(a_sched_end, (pc == ST_K3 && stat.i_last) |=> (pc == ST_POST), "schedule overran")

endmodule

// File: hw/rtl/rc4ks_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rc4ks_dp (
  input  logic                clk,
  input  logic                rst,
  input  rc4ks_pkg::dp_ctl_t  ctl,
  input  rc4ks_pkg::byte_t    key,
  output rc4ks_pkg::dp_stat_t stat,
  output logic                out_valid,
  input  logic                out_stall,
  output rc4ks_pkg::byte_t    keystream_byte
);

  import rc4ks_pkg::*;

  addr_t i;
  addr_t j;
  byte_t ta;
  byte_t tb;
  addr_t sel;
  byte_t res;
  byte_t res_next;

  logic [TBL_DEPTH-1:0] vld;
  logic  vld_q;
  addr_t raddr;
  addr_t raddr_q;
  addr_t waddr;
  byte_t wdata;
  byte_t ram_q;
  byte_t rd;
  byte_t jsum;
  logic  out_free;

  rc4ks_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TBL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // An entry never written since the last clear holds its own index.
  assign rd   = vld_q ? ram_q : byte_t'(raddr_q);
  assign jsum = byte_t'(j) + rd + (ctl.add_key ? key : byte_t'(0));

  always_comb begin
    case (ctl.ra_sel)
      RA_I:      raddr = i;
      RA_I_INC:  raddr = i + addr_t'(1);
      RA_J_SUM:  raddr = addr_t'(jsum);
      RA_TA_SUM: raddr = addr_t'(ta + rd);
      default:   raddr = i;
    endcase
  end

  assign waddr = (ctl.wa_sel == WA_J) ? j : i;
  assign wdata = (ctl.wd_sel == WD_TA) ? ta : rd;

  // The swap lands in memory around the final read: take swapped entries from ta and tb.
  always_comb begin
    if (sel == j) begin
      res_next = ta;
    end else if (sel == i) begin
      res_next = tb;
    end else begin
      res_next = rd;
    end
  end

  assign out_free      = !out_valid || !out_stall;
  assign stat.out_free = out_free;
  assign stat.i_last   = (i == ADDR_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.vld_clr) begin
      vld <= '0;
    end else if (ctl.we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q   <= vld[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
    end else begin
      case (ctl.i_op)
        I_ZERO:  i <= '0;
        I_INC:   i <= i + addr_t'(1);
        default: i <= i;
      endcase
      case (ctl.j_op)
        J_ZERO:  j <= '0;
        J_SUM:   j <= addr_t'(jsum);
        default: j <= j;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_ta) begin
      ta <= rd;
    end
    if (ctl.ld_tb) begin
      tb <= rd;
    end
    if (ctl.ld_sel) begin
      sel <= addr_t'(ta + rd);
    end
    if (ctl.ld_res) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      keystream_byte <= res;
    end
  end

  `ASSERT_CLK(a_emit_load, (ctl.emit && out_free) |=> out_valid, "emitted byte must show on output")
  `ASSERT_CLK(a_vld_set, ctl.we |=> vld[$past(waddr)], "written entry must be marked valid")

endmodule
